[design/fpfa_pkg.sv]
// Shared types and constants for the fixed partition fit allocator.
`default_nettype none
package fpfa_pkg;

   // Payload field widths
   localparam int BLOCK_INDEX_BITS = 4;
   localparam int SIZE_FIELD_BITS  = 16;
   localparam int REQ_NUM_BITS     = 8;
   localparam int POLICY_BITS      = 2;
   localparam int COUNT_BITS       = 5;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   // Item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   // Fit policies; the unused code behaves as first fit
   localparam logic [POLICY_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] FIT_WORST = 2'd2;

   localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic                        mode;
      logic [BLOCK_INDEX_BITS-1:0] block_index;
      logic [SIZE_FIELD_BITS-1:0]  size;
   } req_payload_type;

   typedef struct packed {
      logic                        granted;
      logic [BLOCK_INDEX_BITS-1:0] block_number;
      logic [REQ_NUM_BITS-1:0]     request_number;
      logic [SIZE_FIELD_BITS-1:0]  remaining;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // capture the incoming beat, restart the scan
      logic issue;       // read the next table entry
      logic commit;      // write back and present the result
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_alloc;    // incoming beat is an allocate request
      logic limit_zero;  // no blocks in use
      logic last_issue;  // current read is the last entry in use
      logic out_free;    // result register can take a new result
   } ctl_status_type;

endpackage
`default_nettype wire

[design/fpfa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[design/fpfa_ctrl.sv]
// Sequencer for loads and table scans of the fit allocator.
`default_nettype none
module fpfa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire fpfa_pkg::ctl_status_type status,
   output fpfa_pkg::ctl_cmd_type        cmd
);
   import fpfa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Take a beat only when no item is in flight
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.load_item = accept;
      cmd.issue     = (state_ff == ST_SCAN);
      cmd.commit    = (state_ff == ST_FINISH) && status.out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.in_alloc && !status.limit_zero) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last entry is compared here
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[design/fpfa_datapath.sv]
// Block table, fit compare unit, request counter and result register.
`default_nettype none
module fpfa_datapath #(
   parameter int MAX_BLOCKS   = 16,
   parameter int SIZE_BITS    = 16,
   parameter int MAX_REQUESTS = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fpfa_pkg::ctl_cmd_type                  cmd,
   output fpfa_pkg::ctl_status_type                    status,
   input  wire fpfa_pkg::req_payload_type              req_data,
   input  wire logic [fpfa_pkg::POLICY_BITS-1:0]       fit_policy,
   input  wire logic [fpfa_pkg::COUNT_BITS-1:0]        block_count,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output fpfa_pkg::rsp_payload_type                   rsp_data
);
   import fpfa_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int LW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = (LW > COUNT_BITS) ? LW : COUNT_BITS;
   localparam int RW = $clog2(MAX_REQUESTS);

   // Item registers
   logic                        mode_ff, mode_in;
   logic [BLOCK_INDEX_BITS-1:0] idx_ff, idx_in;
   logic [SIZE_BITS-1:0]        size_ff, size_in;

   // Scan state
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 data_vld_ff, data_vld_in;
   logic [AW-1:0]        data_idx_ff, data_idx_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_left_ff, best_left_in;

   // Request numbering and result register
   logic [RW-1:0]   req_cnt_ff, req_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Table port
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] rd_data;

   logic [CW-1:0]        count_ext;
   logic [CW-1:0]        limit;
   logic                 idx_in_range;
   logic                 fits;
   logic [SIZE_BITS-1:0] left;
   logic                 take;
   logic                 out_free;

   fpfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Blocks in use, saturated to the table depth
   always_comb begin
      count_ext = CW'(block_count);
      if (count_ext > CW'(MAX_BLOCKS)) begin
         limit = CW'(MAX_BLOCKS);
      end else begin
         limit = count_ext;
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign idx_in_range = (32'(idx_ff) < MAX_BLOCKS);

   always_comb begin
      status.in_alloc   = (req_data.mode == MODE_ALLOC);
      status.limit_zero = (limit == '0);
      status.last_issue = ((CW'(addr_ff) + CW'(1)) == limit);
      status.out_free   = out_free;
   end

   // Fit compare on the entry read last cycle
   always_comb begin
      fits = (rd_data >= size_ff);
      left = rd_data - size_ff;
      take = data_vld_ff && fits &&
             (!found_ff ||
              ((fit_policy == FIT_BEST) && (left < best_left_ff)) ||
              ((fit_policy == FIT_WORST) && (left > best_left_ff)));
   end

   // Scan and item registers
   always_comb begin
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_left_in = best_left_ff;
      data_vld_in  = cmd.issue;
      data_idx_in  = addr_ff;
      if (cmd.load_item) begin
         mode_in  = req_data.mode;
         idx_in   = req_data.block_index;
         size_in  = SIZE_BITS'(req_data.size);
         addr_in  = '0;
         found_in = 1'b0;
      end else begin
         if (cmd.issue) begin
            addr_in = addr_ff + AW'(1);
         end
         if (take) begin
            found_in     = 1'b1;
            pick_in      = data_idx_ff;
            best_left_in = left;
         end
      end
   end

   // Write back and result
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = pick_ff;
      wr_data      = best_left_ff;
      req_cnt_in   = req_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (mode_ff == MODE_LOAD) begin
            wr_en                      = idx_in_range;
            wr_addr                    = AW'(idx_ff);
            wr_data                    = size_ff;
            req_cnt_in                 = '0;
            rsp_data_in.granted        = 1'b0;
            rsp_data_in.block_number   = '0;
            rsp_data_in.request_number = '0;
            rsp_data_in.remaining      = SIZE_FIELD_BITS'(size_ff);
         end else begin
            wr_en = found_ff;
            if (32'(req_cnt_ff) == MAX_REQUESTS - 1) begin
               req_cnt_in = '0;
            end else begin
               req_cnt_in = req_cnt_ff + RW'(1);
            end
            rsp_data_in.granted        = found_ff;
            rsp_data_in.request_number = REQ_NUM_BITS'(req_cnt_ff);
            if (found_ff) begin
               rsp_data_in.block_number = BLOCK_INDEX_BITS'(pick_ff);
               rsp_data_in.remaining    = SIZE_FIELD_BITS'(best_left_ff);
            end else begin
               rsp_data_in.block_number = '0;
               rsp_data_in.remaining    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         req_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         data_vld_ff  <= data_vld_in;
         found_ff     <= found_in;
         req_cnt_ff   <= req_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      data_idx_ff  <= data_idx_in;
      pick_ff      <= pick_in;
      best_left_ff <= best_left_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[design/fixed_partition_fit_allocator.sv]
// Top level of the fixed partition fit allocator: register port and instances.
//
// The block keeps a table of remaining block sizes and serves one item at a
// time. A load beat writes one entry and restarts request numbering. An
// allocate beat scans the first block_count entries (saturated to MAX_BLOCKS)
// through the table's single read port, one entry per cycle, applies first,
// best or worst fit, then writes the chosen entry back if one fits; with no
// block in use it goes straight to the result. A finished result waits in an
// output register while the next beat is taken; if that register is still
// held by a stalled result, the block waits in its last cycle until the
// register frees. Table entries hold no value until loaded; the user must
// write fit_policy and block_count only while the block is idle, as the block
// itself does not enforce this.
`default_nettype none
module fixed_partition_fit_allocator #(
   parameter int MAX_BLOCKS   = 16,
   parameter int SIZE_BITS    = 16,
   parameter int MAX_REQUESTS = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire fpfa_pkg::req_payload_type            req_data,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output fpfa_pkg::rsp_payload_type                 rsp_data,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [fpfa_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [fpfa_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [fpfa_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);
   import fpfa_pkg::*;

   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   csr_wr;
   logic                   csr_sel;
   ctl_cmd_type            cmd;
   ctl_status_type         status;

   // Register port: word address selects the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_wr) begin
         case (csr_sel)
            CSR_FIT_POLICY:  policy_in = csr_pwdata[POLICY_BITS-1:0];
            CSR_BLOCK_COUNT: count_in  = csr_pwdata[COUNT_BITS-1:0];
            default: begin
               policy_in = policy_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_FIT_POLICY:  csr_prdata = CSR_DATA_BITS'(policy_ff);
         CSR_BLOCK_COUNT: csr_prdata = CSR_DATA_BITS'(count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
         count_ff  <= BLOCK_COUNT_RESET;
      end else begin
         policy_ff <= policy_in;
         count_ff  <= count_in;
      end
   end

   fpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpfa_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .SIZE_BITS    (SIZE_BITS),
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .fit_policy  (policy_ff),
      .block_count (count_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
